/* hw/rtl/atrlf_pkg.sv */
package atrlf_pkg;

  // Default ring store depth in bytes
  localparam int unsigned DEPTH_DEFAULT = 256;

  // Pending line counter width and its saturation value
  localparam int unsigned COUNT_W = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  // Request codes
  localparam logic [1:0] REQ_FEED    = 2'd0;
  localparam logic [1:0] REQ_COMPARE = 2'd1;
  localparam logic [1:0] REQ_ADVANCE = 2'd2;

  // Character codes
  localparam logic [7:0] CHR_NUL    = 8'h00;
  localparam logic [7:0] CHR_SUBST  = 8'hFF;
  localparam logic [7:0] CHR_PROMPT = 8'h3E;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_LF     = 8'h0A;

endpackage

/* hw/rtl/atrlf_ram.sv */
module atrlf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/at_response_line_framer.sv */
// Response line framer for a serial command link.
// Input channel: a request (in_req_type, in_data_byte, in_first_char,
// in_last_char) is taken at a clock edge where start is high and busy is low.
// Feed stores a byte into the line ring; a CR LF pair or a '>' closes a line.
// Compare checks one expected character against the oldest pending line.
// Advance drops the oldest pending line.
// Result channel: every request gives one result beat, marked by out_valid
// for exactly one cycle; the receiver must take it, it cannot stall.
// out_pending_count and out_has_pending follow the line count at all times.
// Request code 3, a dropped feed and requests that find nothing to do give
// their beat straight from ST_IDLE; feed passes ST_FEED_WR and, if a line
// closes, ST_FEED_TERM; compare ST_CMP_RD0, ST_CMP_RD1, ST_CMP_CHK; advance
// alternates ST_ADV_RD and ST_ADV_CHK for each byte up to the terminator, as
// the line store's single read port has a registered read. busy stays high
// until the result beat; a new request can be taken in the cycle that carries
// out_valid. Reset (rst_n low, synchronous) empties the ring and the line count;
// the store contents are not cleared, and the user must see that entries are
// read only after being written: the block itself does not enforce it.
module at_response_line_framer
  import atrlf_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic [1:0]   in_req_type,
  input  logic [7:0]   in_data_byte,
  input  logic         in_first_char,
  input  logic         in_last_char,
  output logic         out_valid,
  output logic [7:0]   out_pending_count,
  output logic         out_has_pending,
  output logic         out_byte_dropped,
  output logic         out_match_ok,
  output logic         out_match_stop
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_DEPTH - 1);
  localparam logic [CW-1:0] WALK_MAX = CW'(BUFFER_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED_WR,
    ST_FEED_TERM,
    ST_CMP_RD0,
    ST_CMP_RD1,
    ST_CMP_CHK,
    ST_ADV_RD,
    ST_ADV_CHK
  } state_t;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    return (i == '0) ? LAST_IDX : i - AW'(1);
  endfunction

  state_t state_r, state_nxt;
  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [AW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [COUNT_W-1:0] lines_r, lines_nxt;
  logic [7:0] prev_byte_r, prev_byte_nxt;
  logic just_closed_r, just_closed_nxt;
  logic good_r, good_nxt;
  logic [CW-1:0] walk_r, walk_nxt;
  logic valid_r, valid_nxt;
  logic dropped_r, dropped_nxt;
  logic ok_r, ok_nxt;
  logic stop_r, stop_nxt;

  // Payload held across the steps of one request
  logic [7:0] data_r, data_nxt;
  logic last_r, last_nxt;
  logic [AW-1:0] term_r, term_nxt;

  // Line store port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Feed step decode
  logic [7:0]    feed_byte;
  logic          feed_gt;
  logic          feed_close;
  logic [AW-1:0] feed_fwd;

  assign feed_byte  = (data_r == CHR_NUL) ? CHR_SUBST : data_r;
  assign feed_gt    = (feed_byte == CHR_PROMPT);
  assign feed_close = ((prev_byte_r == CHR_CR) && (feed_byte == CHR_LF)) || feed_gt;
  assign feed_fwd   = ring_next(wr_idx_r);

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    wr_idx_nxt      = wr_idx_r;
    rd_idx_nxt      = rd_idx_r;
    cmp_idx_nxt     = cmp_idx_r;
    lines_nxt       = lines_r;
    prev_byte_nxt   = prev_byte_r;
    just_closed_nxt = just_closed_r;
    good_nxt        = good_r;
    walk_nxt        = walk_r;
    valid_nxt       = 1'b0;
    dropped_nxt     = dropped_r;
    ok_nxt          = ok_r;
    stop_nxt        = stop_r;
    data_nxt        = data_r;
    last_nxt        = last_r;
    term_nxt        = term_r;
    ram_we          = 1'b0;
    ram_waddr       = wr_idx_r;
    ram_wdata       = feed_byte;
    ram_raddr       = cmp_idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          data_nxt    = in_data_byte;
          last_nxt    = in_last_char;
          dropped_nxt = 1'b0;
          ok_nxt      = 1'b0;
          stop_nxt    = 1'b0;
          unique case (in_req_type)
            REQ_FEED: begin
              if ((wr_idx_r == rd_idx_r) && (lines_r != '0)) begin
                dropped_nxt = 1'b1;
                valid_nxt   = 1'b1;
              end else begin
                state_nxt = ST_FEED_WR;
              end
            end
            REQ_COMPARE: begin
              if (lines_r == '0) begin
                good_nxt  = 1'b0;
                stop_nxt  = 1'b1;
                valid_nxt = 1'b1;
              end else if (in_first_char) begin
                cmp_idx_nxt = rd_idx_r;
                good_nxt    = 1'b1;
                state_nxt   = ST_CMP_RD0;
              end else if (!good_r) begin
                stop_nxt  = 1'b1;
                valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_CMP_RD0;
              end
            end
            REQ_ADVANCE: begin
              good_nxt = 1'b0;
              if (lines_r == '0) begin
                valid_nxt = 1'b1;
              end else begin
                lines_nxt = lines_r - COUNT_W'(1);
                walk_nxt  = '0;
                state_nxt = ST_ADV_RD;
              end
            end
            default: begin
              valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // Store the byte, then close the line or move on
      ST_FEED_WR: begin
        ram_we    = 1'b1;
        ram_waddr = wr_idx_r;
        ram_wdata = feed_byte;
        if (!feed_close) begin
          if (feed_byte != CHR_CR) begin
            just_closed_nxt = 1'b0;
          end
          prev_byte_nxt = feed_byte;
          wr_idx_nxt    = feed_fwd;
          valid_nxt     = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          if ((!just_closed_r || feed_gt) && (lines_r != COUNT_MAX)) begin
            lines_nxt = lines_r + COUNT_W'(1);
          end
          just_closed_nxt = 1'b1;
          prev_byte_nxt   = CHR_NUL;
          if (feed_gt) begin
            term_nxt = (feed_fwd == rd_idx_r) ? wr_idx_r : feed_fwd;
          end else if (!just_closed_r) begin
            term_nxt = ring_prev(wr_idx_r);
          end else begin
            // fold a repeated CR LF away
            term_nxt = ring_prev(ring_prev(wr_idx_r));
          end
          state_nxt = ST_FEED_TERM;
        end
      end

      // Write the terminator
      ST_FEED_TERM: begin
        ram_we     = 1'b1;
        ram_waddr  = term_r;
        ram_wdata  = CHR_NUL;
        wr_idx_nxt = ring_next(term_r);
        valid_nxt  = 1'b1;
        state_nxt  = ST_IDLE;
      end

      ST_CMP_RD0: begin
        ram_raddr = cmp_idx_r;
        state_nxt = ST_CMP_RD1;
      end

      // Check this character, fetch the one after it
      ST_CMP_RD1: begin
        ram_raddr   = ring_next(cmp_idx_r);
        ok_nxt      = (ram_rdata == data_r);
        cmp_idx_nxt = ring_next(cmp_idx_r);
        state_nxt   = ST_CMP_CHK;
      end

      ST_CMP_CHK: begin
        stop_nxt  = !ok_r || (ram_rdata == CHR_NUL) || last_r;
        good_nxt  = ok_r && (ram_rdata != CHR_NUL) && !last_r;
        valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end

      // Walk the oldest line up to its terminator
      ST_ADV_RD: begin
        ram_raddr = rd_idx_r;
        if (walk_r == WALK_MAX) begin
          rd_idx_nxt = ring_next(rd_idx_r);
          valid_nxt  = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_ADV_CHK;
        end
      end

      ST_ADV_CHK: begin
        rd_idx_nxt = ring_next(rd_idx_r);
        if (ram_rdata == CHR_NUL) begin
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          walk_nxt  = walk_r + CW'(1);
          state_nxt = ST_ADV_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      wr_idx_r      <= '0;
      rd_idx_r      <= '0;
      cmp_idx_r     <= '0;
      lines_r       <= '0;
      prev_byte_r   <= CHR_NUL;
      just_closed_r <= 1'b0;
      good_r        <= 1'b0;
      walk_r        <= '0;
      valid_r       <= 1'b0;
      dropped_r     <= 1'b0;
      ok_r          <= 1'b0;
      stop_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      wr_idx_r      <= wr_idx_nxt;
      rd_idx_r      <= rd_idx_nxt;
      cmp_idx_r     <= cmp_idx_nxt;
      lines_r       <= lines_nxt;
      prev_byte_r   <= prev_byte_nxt;
      just_closed_r <= just_closed_nxt;
      good_r        <= good_nxt;
      walk_r        <= walk_nxt;
      valid_r       <= valid_nxt;
      dropped_r     <= dropped_nxt;
      ok_r          <= ok_nxt;
      stop_r        <= stop_nxt;
    end
  end

  // Hold request payload
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
    term_r <= term_nxt;
  end

  atrlf_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = valid_r;
  assign out_pending_count = lines_r;
  assign out_has_pending   = (lines_r != '0);
  assign out_byte_dropped  = dropped_r;
  assign out_match_ok      = ok_r;
  assign out_match_stop    = stop_r;

`ifndef SYNTHESIS
  a_done_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("sequencer left a request without a result beat");

  a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while a request is still at work");

  a_drop_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_dropped) |-> (!out_match_ok && !out_match_stop))
    else $error("dropped byte reported together with compare status");

  a_match_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_match_ok) |-> out_has_pending)
    else $error("match reported with no pending line");
`endif

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import atrlf_pkg::*;

  localparam logic [1:0]  REQ_NONE       = 2'd3;
  localparam int unsigned RING_DEPTH     = DEPTH_DEFAULT;
  localparam int unsigned ITEM_TARGET    = 850;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam logic [7:0]  CHR_FILL       = 8'h41;

  typedef struct packed {
    logic [7:0] pending_count;
    logic       has_pending;
    logic       byte_dropped;
    logic       match_ok;
    logic       match_stop;
  } status_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_req_type;
  logic [7:0] in_data_byte;
  logic       in_first_char;
  logic       in_last_char;
  logic       out_valid;
  logic [7:0] out_pending_count;
  logic       out_has_pending;
  logic       out_byte_dropped;
  logic       out_match_ok;
  logic       out_match_stop;

  // Mirror of the line ring and its pointers
  logic [7:0]  line_mem [RING_DEPTH];
  bit          written [RING_DEPTH];
  int unsigned wr_pos;
  int unsigned rd_pos;
  int unsigned cmp_pos;
  int unsigned lines_pending;
  logic [7:0]  last_stored;
  bit          just_closed;
  bit          cmp_active;

  status_t     status_q [$];
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned req_seen [4];
  int unsigned drops_seen;
  int unsigned peak_lines;
  int unsigned burst_left;
  int unsigned idle_cycles;

  at_response_line_framer #(
    .BUFFER_DEPTH(RING_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_data_byte     (in_data_byte),
    .in_first_char    (in_first_char),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_pending_count(out_pending_count),
    .out_has_pending  (out_has_pending),
    .out_byte_dropped (out_byte_dropped),
    .out_match_ok     (out_match_ok),
    .out_match_stop   (out_match_stop)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned ring_fwd(input int unsigned i);
    return (i + 1 >= RING_DEPTH) ? 0 : i + 1;
  endfunction

  function automatic int unsigned ring_back(input int unsigned i);
    return (i == 0) ? RING_DEPTH - 1 : i - 1;
  endfunction

  function automatic void clear_ring();
    for (int i = 0; i < RING_DEPTH; i++) begin
      line_mem[i] = CHR_NUL;
      written[i]  = 1'b0;
    end
    wr_pos        = 0;
    rd_pos        = 0;
    cmp_pos       = 0;
    lines_pending = 0;
    last_stored   = CHR_NUL;
    just_closed   = 1'b0;
    cmp_active    = 1'b0;
  endfunction

  function automatic void put_entry(input int unsigned pos, input logic [7:0] value);
    line_mem[pos] = value;
    written[pos]  = 1'b1;
  endfunction

  // Store one received byte; returns 1 when the byte is dropped
  function automatic bit store_byte(input logic [7:0] rx);
    logic [7:0]  value;
    int unsigned keep;
    if (wr_pos == rd_pos && lines_pending != 0) return 1'b1;
    value = (rx == CHR_NUL) ? CHR_SUBST : rx;
    put_entry(wr_pos, value);
    if ((last_stored == CHR_CR && value == CHR_LF) || value == CHR_PROMPT) begin
      // close a line, or fold a CR LF that follows a closed line
      if (!just_closed || value == CHR_PROMPT) begin
        if (lines_pending < COUNT_MAX) lines_pending++;
      end else begin
        wr_pos = ring_back(wr_pos);
      end
      just_closed = 1'b1;
      if (value == CHR_PROMPT) begin
        // keep the write position off the read position
        keep   = wr_pos;
        wr_pos = ring_fwd(wr_pos);
        if (wr_pos == rd_pos) wr_pos = keep;
      end else begin
        wr_pos = ring_back(wr_pos);
      end
      put_entry(wr_pos, CHR_NUL);
    end else if (value != CHR_CR) begin
      just_closed = 1'b0;
    end
    last_stored = line_mem[wr_pos];
    wr_pos      = ring_fwd(wr_pos);
    return 1'b0;
  endfunction

  // Skip past the oldest line and its terminator
  function automatic void drop_oldest_line();
    int unsigned n;
    cmp_active = 1'b0;
    if (lines_pending == 0) return;
    lines_pending--;
    for (n = 0; n < RING_DEPTH && line_mem[rd_pos] != CHR_NUL; n++) rd_pos = ring_fwd(rd_pos);
    rd_pos = ring_fwd(rd_pos);
  endfunction

  // Work out the status beat for one request and update the mirror
  function automatic status_t apply_request(input logic [1:0] req, input logic [7:0] data,
                                            input logic first_c, input logic last_c);
    status_t res;
    res = '0;
    case (req)
      REQ_FEED: begin
        res.byte_dropped = store_byte(data);
      end
      REQ_COMPARE: begin
        if (lines_pending == 0) begin
          cmp_active     = 1'b0;
          res.match_stop = 1'b1;
        end else begin
          if (first_c) begin
            cmp_pos    = rd_pos;
            cmp_active = 1'b1;
          end
          if (!cmp_active) begin
            res.match_stop = 1'b1;
          end else begin
            res.match_ok   = (line_mem[cmp_pos] == data);
            cmp_pos        = ring_fwd(cmp_pos);
            res.match_stop = !res.match_ok || line_mem[cmp_pos] == CHR_NUL || last_c;
            cmp_active     = !res.match_stop;
          end
        end
      end
      REQ_ADVANCE: begin
        drop_oldest_line();
      end
      default: ;
    endcase
    res.pending_count = 8'(lines_pending);
    res.has_pending   = (lines_pending != 0);
    return res;
  endfunction

  // A compare must only look at entries that have been written
  function automatic bit compare_is_safe(input bit restart);
    int unsigned pos;
    if (lines_pending == 0) return 1'b1;
    if (!restart && !cmp_active) return 1'b1;
    pos = restart ? rd_pos : cmp_pos;
    return written[pos] && written[ring_fwd(pos)];
  endfunction

  // Drive one request beat, in bursts with random gaps, and hold until taken
  task automatic send_beat(input logic [1:0] req, input logic [7:0] data,
                           input logic first_c, input logic last_c, output status_t got);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      gap        = $urandom_range(0, 5);
      if (gap != 0) begin
        @(negedge clk);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    start         = 1'b1;
    in_req_type   = req;
    in_data_byte  = data;
    in_first_char = first_c;
    in_last_char  = last_c;
    do @(posedge clk); while (busy);
    got = apply_request(req, data, first_c, last_c);
    status_q.push_back(got);
    if (req != REQ_NONE) items_sent++;
    req_seen[req]++;
    if (got.byte_dropped) drops_seen++;
    if (lines_pending > peak_lines) peak_lines = lines_pending;
  endtask

  task automatic feed(input logic [7:0] rx);
    status_t got;
    send_beat(REQ_FEED, rx, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), got);
  endtask

  task automatic advance_line();
    status_t got;
    send_beat(REQ_ADVANCE, 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              got);
  endtask

  task automatic compare(input logic [7:0] data, input logic first_c, input logic last_c);
    status_t got;
    send_beat(REQ_COMPARE, data, first_c, last_c, got);
  endtask

  // Walk the oldest line with expected characters, sometimes cut short or wrong
  task automatic compare_oldest();
    int unsigned len;
    int unsigned pos;
    int unsigned cut;
    int unsigned wrong_at;
    bit          with_error;
    logic [7:0]  want;
    status_t     got;
    len = 0;
    pos = rd_pos;
    while (lines_pending != 0 && line_mem[pos] != CHR_NUL && len < RING_DEPTH) begin
      len++;
      pos = ring_fwd(pos);
    end
    cut        = (len <= 32 && $urandom_range(0, 1)) ? len
                                                     : $urandom_range(0, (len > 16) ? 15 : len);
    with_error = ($urandom_range(0, 3) == 0);
    wrong_at   = $urandom_range(0, cut);
    for (int i = 0; i < 300; i++) begin
      if (!compare_is_safe(i == 0)) break;
      want = (i == 0) ? line_mem[rd_pos] : line_mem[cmp_pos];
      if (with_error && i == wrong_at) want ^= 8'($urandom_range(1, 255));
      send_beat(REQ_COMPARE, want, i == 0, i == cut, got);
      if (got.match_stop) break;
    end
    // now and then poke once more after the comparison has ended
    if ($urandom_range(0, 3) == 0) compare(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic feed_random_line();
    int unsigned len;
    int unsigned pick;
    logic [7:0]  rx;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) : $urandom_range(0, 10);
    repeat (len) begin
      if ($urandom_range(0, 99) < 85) begin
        rx = 8'($urandom_range(8'h20, 8'h7E));
        if (rx == CHR_PROMPT) rx = 8'h3C;
      end else begin
        rx = 8'($urandom);
      end
      feed(rx);
    end
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      feed(CHR_CR);
      feed(CHR_LF);
    end else if (pick < 90) begin
      feed(CHR_PROMPT);
    end else if (pick < 95) begin
      repeat (2) begin
        feed(CHR_CR);
        feed(CHR_LF);
      end
    end
  endtask

  // Nothing to compare or skip, and the unused request code
  task automatic test_idle_requests();
    status_t got;
    compare(8'h00, 1'b1, 1'b0);
    send_beat(REQ_ADVANCE, 8'hFF, 1'b1, 1'b1, got);
    send_beat(REQ_NONE, 8'hFF, 1'b1, 1'b1, got);
    compare(8'hFF, 1'b0, 1'b1);
  endtask

  // NUL substitution, CR LF close, folded CR LF, prompt close
  task automatic test_line_closing();
    feed(8'h00);
    feed(8'hFF);
    feed(CHR_CR);
    feed(CHR_LF);
    feed(CHR_CR);
    feed(CHR_LF);
    feed(CHR_PROMPT);
    feed(CHR_CR);
    feed(CHR_LF);
  endtask

  // Match, line end, no active comparison, mismatch, last character, advance
  task automatic test_compare_rules();
    compare(8'hFF, 1'b1, 1'b0);
    compare(8'hFF, 1'b0, 1'b0);
    compare(8'hFF, 1'b0, 1'b0);
    compare(8'h00, 1'b1, 1'b0);
    compare(8'hFF, 1'b1, 1'b1);
    compare(8'hFF, 1'b1, 1'b0);
    advance_line();
    compare(CHR_PROMPT, 1'b0, 1'b0);
    compare(CHR_PROMPT, 1'b1, 1'b0);
    advance_line();
    advance_line();
  endtask

  // Fill the ring up to the read position, with or without a prompt at the edge
  task automatic test_store_full(input bit prompt_edge);
    int unsigned guard;
    logic [7:0]  rx;
    feed(8'h4F);
    feed(8'h4B);
    feed(CHR_CR);
    feed(CHR_LF);
    guard = 0;
    while (wr_pos != (prompt_edge ? ring_back(rd_pos) : rd_pos) && guard < 2 * RING_DEPTH) begin
      rx = 8'($urandom);
      if (rx == CHR_CR || rx == CHR_LF || rx == CHR_PROMPT) rx = CHR_FILL;
      feed(rx);
      guard++;
    end
    if (prompt_edge) feed(CHR_PROMPT);
    // these land on a full ring and are dropped
    feed(CHR_CR);
    feed(CHR_LF);
    feed(CHR_FILL);
    while (lines_pending != 0) begin
      compare_oldest();
      advance_line();
    end
    feed(CHR_CR);
    feed(CHR_LF);
    while (lines_pending != 0) begin
      compare_oldest();
      advance_line();
    end
  endtask

  // Mostly framed lines checked and skipped, the rest noise
  task automatic test_random_traffic();
    int unsigned pick;
    logic [1:0]  req;
    status_t     got;
    while (items_sent < ITEM_TARGET) begin
      pick = (lines_pending >= 8) ? 60 : $urandom_range(0, 99);
      if (pick < 45) begin
        feed_random_line();
      end else if (pick < 75) begin
        compare_oldest();
        if ($urandom_range(0, 3) != 0) advance_line();
      end else if (pick < 85) begin
        advance_line();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          req = 2'($urandom_range(0, 3));
          pick = $urandom_range(0, 1);
          if (req == REQ_COMPARE && !compare_is_safe(pick[0])) req = REQ_ADVANCE;
          send_beat(req, 8'($urandom), pick[0], 1'($urandom_range(0, 1)), got);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      fail_count++;
    end
  endtask

  // Check every result beat against the oldest expectation
  always @(posedge clk) begin
    status_t want;
    if (rst_n && out_valid) begin
      if (status_q.size() == 0) begin
        $error("result beat with no request waiting");
        fail_count++;
      end else begin
        want = status_q.pop_front();
        check_field("pending_count", want.pending_count, out_pending_count);
        check_field("has_pending", want.has_pending, out_has_pending);
        check_field("byte_dropped", want.byte_dropped, out_byte_dropped);
        check_field("match_ok", want.match_ok, out_match_ok);
        check_field("match_stop", want.match_stop, out_match_stop);
      end
    end
  end

  // End the run when neither side has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_req_type   = REQ_NONE;
    in_data_byte  = 8'h00;
    in_first_char = 1'b0;
    in_last_char  = 1'b0;
    fail_count    = 0;
    items_sent    = 0;
    drops_seen    = 0;
    peak_lines    = 0;
    burst_left    = 0;
    idle_cycles   = 0;
    req_seen      = '{default: 0};
    clear_ring();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_requests();
    test_line_closing();
    test_compare_rules();
    test_store_full(1'b0);
    test_store_full(1'b1);
    test_random_traffic();

    // drain outstanding beats, then let the block settle
    @(negedge clk);
    start = 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d requests: %0d feed, %0d compare, %0d advance, %0d unused code",
             items_sent + req_seen[REQ_NONE], req_seen[REQ_FEED], req_seen[REQ_COMPARE],
             req_seen[REQ_ADVANCE], req_seen[REQ_NONE]);
    $display("%0d bytes dropped on a full ring, up to %0d lines waiting at once",
             drops_seen, peak_lines);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
